[rtl/utf8sc_pkg.sv]
// utf8sc_pkg: types, constants and byte classing functions for the utf8 sequence collector
// depends on nothing; used by utf8sc_step, utf8sc_fifo, the top level and the bench
`timescale 1ns / 1ps

package utf8sc_pkg;

    // result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // fixed byte values
    localparam logic [31:0] REPL_BYTES = 32'h00EF_BFBD;
    localparam logic [31:0] UTF8_BOM   = 32'h00EF_BBBF;
    localparam logic [15:0] BOM16_BE   = 16'hFEFF;
    localparam logic [15:0] BOM16_LE   = 16'hFFFE;
    localparam logic [7:0]  BYTE_C0    = 8'hC0;
    localparam logic [7:0]  BYTE_C1    = 8'hC1;
    localparam logic [7:0]  BYTE_F5    = 8'hF5;

    // open sequence kinds
    localparam logic [2:0] LK_IDLE = 3'd0;
    localparam logic [2:0] LK_SEQ2 = 3'd2;
    localparam logic [2:0] LK_SEQ3 = 3'd3;
    localparam logic [2:0] LK_SEQ4 = 3'd4;
    localparam logic [2:0] LK_PAIR = 3'd5;

    // error codes
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_TRAIL   = 3'd1;
    localparam logic [2:0] ERR_LEAD_C0 = 3'd2;
    localparam logic [2:0] ERR_LEAD_F5 = 3'd3;
    localparam logic [2:0] ERR_STRAY   = 3'd4;

    // byte order mark codes
    localparam logic [1:0] BOM_NONE  = 2'd0;
    localparam logic [1:0] BOM_UTF8  = 2'd1;
    localparam logic [1:0] BOM_UTF16_BE = 2'd2;
    localparam logic [1:0] BOM_UTF16_LE = 2'd3;

    typedef struct packed {
        logic [31:0] char_bytes;
        logic [2:0]  char_len;
        logic [2:0]  error_kind;
        logic [1:0]  bom_kind;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic [2:0]  lead_kind;
        logic [1:0]  filled_count;
        logic [23:0] held_bytes;
    } t_state;

    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_push;

    typedef struct packed {
        t_state next;
        t_push  push;
    } t_step;

    typedef struct packed {
        logic    emit;
        t_result res;
        t_state  st;
    } t_lead;

    localparam t_state IDLE_STATE = '{lead_kind: LK_IDLE, filled_count: 2'd0, held_bytes: 24'd0};

    function automatic t_result repl_result(input logic [2:0] err, input logic [1:0] bom);
        t_result r;
        r.char_bytes  = REPL_BYTES;
        r.char_len    = 3'd3;
        r.error_kind  = err;
        r.bom_kind    = bom;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    function automatic logic valid_lead(input logic [7:0] b);
        return (b <= 8'h7F) || (b > BYTE_C1 && b < BYTE_F5);
    endfunction

    // a byte seen while no sequence is open
    function automatic t_lead take_lead(input logic [7:0] b);
        t_lead t;
        t.emit = 1'b0;
        t.res  = repl_result(ERR_NONE, BOM_NONE);
        t.st   = IDLE_STATE;
        if (b <= 8'h7F) begin
            t.emit           = 1'b1;
            t.res.char_bytes = {24'd0, b};
            t.res.char_len   = 3'd1;
        end else if (b <= 8'hBF) begin
            t.emit = 1'b1;
            t.res  = repl_result(ERR_STRAY, BOM_NONE);
        end else if (b <= BYTE_C1) begin
            t.emit = 1'b1;
            t.res  = repl_result(ERR_LEAD_C0, BOM_NONE);
        end else begin
            t.st.filled_count = 2'd1;
            t.st.held_bytes   = {16'd0, b};
            if (b <= 8'hDF) begin
                t.st.lead_kind = LK_SEQ2;
            end else if (b <= 8'hEF) begin
                t.st.lead_kind = LK_SEQ3;
            end else if (b < BYTE_F5) begin
                t.st.lead_kind = LK_SEQ4;
            end else begin
                t.st.lead_kind = LK_PAIR;
            end
        end
        return t;
    endfunction

endpackage

[rtl/utf8sc_channels.sv]
// utf8sc_byte_if and utf8sc_char_if: valid/ready channels of the utf8 sequence collector
// depends on nothing
`timescale 1ns / 1ps

interface utf8sc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface utf8sc_char_if;
    logic        valid;
    logic        ready;
    logic [31:0] char_bytes;
    logic [2:0]  char_len;
    logic [2:0]  error_kind;
    logic [1:0]  bom_kind;
    logic        last_of_run;

    modport source (output valid, output char_bytes, output char_len, output error_kind,
                    output bom_kind, output last_of_run, input ready);
    modport sink   (input valid, input char_bytes, input char_len, input error_kind,
                    input bom_kind, input last_of_run, output ready);
endinterface

[rtl/utf8sc_step.sv]
// utf8sc_step: next state and up to two results for one byte
// depends on utf8sc_pkg
`timescale 1ns / 1ps

module utf8sc_step (
    input  utf8sc_pkg::t_state i_state,
    input  logic [7:0]         i_byte,
    output utf8sc_pkg::t_step  o_step
);

    utf8sc_pkg::t_lead tl;
    logic [15:0] pair;
    logic [31:0] packed_bytes;
    logic [2:0]  cnt;
    logic        is_trail;

    assign tl           = utf8sc_pkg::take_lead(i_byte);
    assign pair         = {i_state.held_bytes[7:0], i_byte};
    assign packed_bytes = {i_state.held_bytes, i_byte};
    assign cnt          = {1'b0, i_state.filled_count} + 3'd1;
    assign is_trail     = (i_byte[7:6] == 2'b10);

    always_comb begin
        o_step.next    = i_state;
        o_step.push.n  = 2'd0;
        o_step.push.r0 = utf8sc_pkg::repl_result(utf8sc_pkg::ERR_NONE, utf8sc_pkg::BOM_NONE);
        o_step.push.r1 = tl.res;
        case (i_state.lead_kind) inside
            utf8sc_pkg::LK_SEQ2, utf8sc_pkg::LK_SEQ3, utf8sc_pkg::LK_SEQ4: begin
                if (is_trail) begin
                    if (cnt >= i_state.lead_kind) begin
                        o_step.next                = utf8sc_pkg::IDLE_STATE;
                        o_step.push.n              = 2'd1;
                        o_step.push.r0.char_bytes  = packed_bytes;
                        o_step.push.r0.char_len    = i_state.lead_kind;
                        if (i_state.lead_kind == utf8sc_pkg::LK_SEQ3 &&
                            packed_bytes == utf8sc_pkg::UTF8_BOM) begin
                            o_step.push.r0.bom_kind = utf8sc_pkg::BOM_UTF8;
                        end
                    end else begin
                        o_step.next.held_bytes   = packed_bytes[23:0];
                        o_step.next.filled_count = cnt[1:0];
                    end
                end else begin
                    // broken sequence, then the byte may open a new one
                    o_step.next    = utf8sc_pkg::IDLE_STATE;
                    o_step.push.n  = 2'd1;
                    o_step.push.r0 = utf8sc_pkg::repl_result(utf8sc_pkg::ERR_TRAIL,
                                                             utf8sc_pkg::BOM_NONE);
                    if (utf8sc_pkg::valid_lead(i_byte)) begin
                        o_step.next = tl.st;
                        if (tl.emit) begin
                            o_step.push.n = 2'd2;
                        end
                    end
                end
            end
            utf8sc_pkg::LK_PAIR: begin
                // both byte order mark pairs end in a byte that is no valid lead
                o_step.next    = utf8sc_pkg::IDLE_STATE;
                o_step.push.n  = 2'd1;
                o_step.push.r0 = utf8sc_pkg::repl_result(utf8sc_pkg::ERR_LEAD_F5,
                                                         utf8sc_pkg::BOM_NONE);
                if (pair == utf8sc_pkg::BOM16_BE) begin
                    o_step.push.r0.bom_kind = utf8sc_pkg::BOM_UTF16_BE;
                end else if (pair == utf8sc_pkg::BOM16_LE) begin
                    o_step.push.r0.bom_kind = utf8sc_pkg::BOM_UTF16_LE;
                end
                if (utf8sc_pkg::valid_lead(i_byte)) begin
                    o_step.next = tl.st;
                    if (tl.emit) begin
                        o_step.push.n = 2'd2;
                    end
                end
            end
            default: begin
                o_step.next = tl.st;
                if (tl.emit) begin
                    o_step.push.n  = 2'd1;
                    o_step.push.r0 = tl.res;
                end
            end
        endcase
        o_step.push.r0.last_of_run = (o_step.push.n == 2'd1);
        o_step.push.r1.last_of_run = 1'b1;
    end

endmodule

[rtl/utf8sc_fifo.sv]
// utf8sc_fifo: small result queue, up to two writes and one read per cycle
// depends on utf8sc_pkg
`timescale 1ns / 1ps

module utf8sc_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  utf8sc_pkg::t_push   i_push,
    input  logic                i_pop,
    output logic                o_valid,
    output logic                o_room2,
    output utf8sc_pkg::t_result o_head
);

    localparam int AW = utf8sc_pkg::FIFO_AW;

    utf8sc_pkg::t_result r_mem [utf8sc_pkg::FIFO_DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [AW:0]   r_count, n_count;
    logic [AW-1:0] wr_next;

    assign wr_next = r_wr + AW'(1);
    assign n_wr    = r_wr + AW'(i_push.n);
    assign n_rd    = r_rd + AW'(i_pop);
    assign n_count = r_count + (AW+1)'(i_push.n) - (AW+1)'(i_pop);

    assign o_valid = (r_count != '0);
    assign o_room2 = (r_count <= (AW+1)'(utf8sc_pkg::FIFO_DEPTH - 2));
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[wr_next] <= i_push.r1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(utf8sc_pkg::FIFO_DEPTH))
        else $error("result queue overfilled");

    a_pair_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.n == 2'd2 |-> r_count <= (AW+1)'(utf8sc_pkg::FIFO_DEPTH - 2))
        else $error("two results pushed without room");

    a_run_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_head.last_of_run) |-> r_count >= (AW+1)'(2))
        else $error("first result of a byte queued without its partner");

endmodule

[rtl/utf8_sequence_collector.sv]
// utf8_sequence_collector: top level, collects utf8 byte sequences into packed characters
// depends on utf8sc_pkg, utf8sc_channels, utf8sc_step, utf8sc_fifo
// the results of an accepted byte are written into the registered result queue
// throughput: one byte per cycle unless stalled; two results leave one at a time
// the input stalls only when the four-entry result queue has fewer than two free slots
// reset: synchronous active low, closes any open sequence and empties the result queue
`timescale 1ns / 1ps

module utf8_sequence_collector (
    input  logic          i_clk,
    input  logic          i_rst_n,
    utf8sc_byte_if.sink   i_byte,
    utf8sc_char_if.source o_char
);

    // sequence state: open kind, bytes collected so far, and the bytes themselves
    utf8sc_pkg::t_state  r_state, n_state;
    utf8sc_pkg::t_step   step;
    utf8sc_pkg::t_push   push;
    utf8sc_pkg::t_result head;
    logic                accept;
    logic                room2;
    logic                pop;
    logic                head_valid;

    // a transaction in is taken whenever the queue can absorb a worst case byte
    assign i_byte.ready = room2;
    assign accept       = i_byte.valid && room2;

    // classing, packing and error detection for the incoming byte
    utf8sc_step u_step (
        .i_state (r_state),
        .i_byte  (i_byte.in_byte),
        .o_step  (step)
    );

    // only an accepted byte moves the state or pushes results
    assign n_state = accept ? step.next : r_state;

    always_comb begin
        push = step.push;
        if (!accept) begin
            push.n = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= utf8sc_pkg::IDLE_STATE;
        end else begin
            r_state <= n_state;
        end
    end

    // result queue parts the input side from the output handshake
    assign pop = head_valid && o_char.ready;

    utf8sc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_room2 (room2),
        .o_head  (head)
    );

    assign o_char.valid       = head_valid;
    assign o_char.char_bytes  = head.char_bytes;
    assign o_char.char_len    = head.char_len;
    assign o_char.error_kind  = head.error_kind;
    assign o_char.bom_kind    = head.bom_kind;
    assign o_char.last_of_run = head.last_of_run;

    // a pending f5-ff byte is always held alone
    a_pair_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.lead_kind == utf8sc_pkg::LK_PAIR |-> r_state.filled_count == 2'd1)
        else $error("pending f5-ff byte with wrong fill");

    // an open sequence holds at least its lead and is never full
    a_open_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.lead_kind == utf8sc_pkg::LK_SEQ2 || r_state.lead_kind == utf8sc_pkg::LK_SEQ3 ||
         r_state.lead_kind == utf8sc_pkg::LK_SEQ4)
        |-> (r_state.filled_count != 2'd0 &&
             {1'b0, r_state.filled_count} < r_state.lead_kind))
        else $error("open sequence fill out of range");

    // idle state carries no leftover bytes
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.lead_kind == utf8sc_pkg::LK_IDLE
        |-> (r_state.filled_count == 2'd0 && r_state.held_bytes == 24'd0))
        else $error("idle state holds stale bytes");

endmodule

[bench/utf8_sequence_collector_tb.sv]
// utf8_sequence_collector_tb: self-checking bench for the utf8 sequence collector
// drives a byte stream, predicts every packed character and checks each one in order
// depends on utf8sc_pkg, utf8sc_channels and the utf8_sequence_collector top level
`timescale 1ns / 1ps

module utf8_sequence_collector_tb;

    logic i_clk;
    logic i_rst_n;

    utf8sc_byte_if byte_ch ();
    utf8sc_char_if char_ch ();

    utf8_sequence_collector dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch.sink),
        .o_char  (char_ch.source)
    );

    // idling pressure of the current phase, in percent of cycles
    int sender_idle_pct;
    int recv_stall_pct;

    // counters
    int bytes_sent;
    int chars_checked;
    int mismatches;

    // characters predicted but not yet seen on the output
    utf8sc_pkg::t_result pending_chars[$];

    // predictor copy of the collector state
    logic [2:0]  pred_lead;
    logic [1:0]  pred_fill;
    logic [23:0] pred_held;

    // results produced by the byte being predicted, at most two
    utf8sc_pkg::t_result step_out[0:1];
    int                  step_cnt;

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver side: ready is redrawn every falling edge
    initial begin
        char_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            char_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // safety net against a hung handshake
    initial begin
        #5_000_000;
        $display("timeout: %0d characters still pending", pending_chars.size());
        $display("[utf8_sequence_collector] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic utf8sc_pkg::t_result fallback_char(input logic [2:0] err,
                                                          input logic [1:0] bom);
        utf8sc_pkg::t_result r;
        r.char_bytes  = utf8sc_pkg::REPL_BYTES;
        r.char_len    = 3'd3;
        r.error_kind  = err;
        r.bom_kind    = bom;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    function automatic logic is_lead_byte(input logic [7:0] b);
        return (b <= 8'h7F) || (b >= 8'hC2 && b <= 8'hF4);
    endfunction

    task automatic add_step_result(input utf8sc_pkg::t_result r);
        step_out[step_cnt] = r;
        step_cnt++;
    endtask

    task automatic close_pred_seq();
        pred_lead = utf8sc_pkg::LK_IDLE;
        pred_fill = 2'd0;
        pred_held = 24'd0;
    endtask

    // byte arriving while no sequence is open
    task automatic start_char(input logic [7:0] b);
        utf8sc_pkg::t_result r;
        if (b <= 8'h7F) begin
            r = fallback_char(utf8sc_pkg::ERR_NONE, utf8sc_pkg::BOM_NONE);
            r.char_bytes = {24'd0, b};
            r.char_len   = 3'd1;
            add_step_result(r);
        end else if (b <= 8'hBF) begin
            // trailing byte with nothing open
            add_step_result(fallback_char(utf8sc_pkg::ERR_STRAY, utf8sc_pkg::BOM_NONE));
        end else if (b == utf8sc_pkg::BYTE_C0 || b == utf8sc_pkg::BYTE_C1) begin
            add_step_result(fallback_char(utf8sc_pkg::ERR_LEAD_C0, utf8sc_pkg::BOM_NONE));
        end else begin
            pred_fill = 2'd1;
            pred_held = {16'd0, b};
            if (b <= 8'hDF) begin
                pred_lead = utf8sc_pkg::LK_SEQ2;
            end else if (b <= 8'hEF) begin
                pred_lead = utf8sc_pkg::LK_SEQ3;
            end else if (b < utf8sc_pkg::BYTE_F5) begin
                pred_lead = utf8sc_pkg::LK_SEQ4;
            end else begin
                // F5-FF waits for its partner byte
                pred_lead = utf8sc_pkg::LK_PAIR;
            end
        end
    endtask

    task automatic predict_byte(input logic [7:0] b);
        logic [15:0]         pair;
        logic [31:0]         packed_bytes;
        int                  cnt;
        utf8sc_pkg::t_result r;
        step_cnt = 0;
        case (pred_lead) inside
            utf8sc_pkg::LK_PAIR: begin
                pair = {pred_held[7:0], b};
                close_pred_seq();
                if (pair == utf8sc_pkg::BOM16_BE) begin
                    add_step_result(fallback_char(utf8sc_pkg::ERR_LEAD_F5,
                                                  utf8sc_pkg::BOM_UTF16_BE));
                end else if (pair == utf8sc_pkg::BOM16_LE) begin
                    add_step_result(fallback_char(utf8sc_pkg::ERR_LEAD_F5,
                                                  utf8sc_pkg::BOM_UTF16_LE));
                end else begin
                    add_step_result(fallback_char(utf8sc_pkg::ERR_LEAD_F5,
                                                  utf8sc_pkg::BOM_NONE));
                    if (is_lead_byte(b)) start_char(b);
                end
            end
            utf8sc_pkg::LK_SEQ2, utf8sc_pkg::LK_SEQ3, utf8sc_pkg::LK_SEQ4: begin
                if (b >= 8'h80 && b <= 8'hBF) begin
                    packed_bytes = {pred_held, b};
                    cnt = pred_fill + 1;
                    if (cnt >= pred_lead) begin
                        r = fallback_char(utf8sc_pkg::ERR_NONE, utf8sc_pkg::BOM_NONE);
                        r.char_bytes = packed_bytes;
                        r.char_len   = pred_lead;
                        if (pred_lead == utf8sc_pkg::LK_SEQ3 &&
                            packed_bytes == utf8sc_pkg::UTF8_BOM)
                            r.bom_kind = utf8sc_pkg::BOM_UTF8;
                        add_step_result(r);
                        close_pred_seq();
                    end else begin
                        pred_held = packed_bytes[23:0];
                        pred_fill = cnt[1:0];
                    end
                end else begin
                    // open sequence broken by a non-trailing byte
                    close_pred_seq();
                    add_step_result(fallback_char(utf8sc_pkg::ERR_TRAIL, utf8sc_pkg::BOM_NONE));
                    if (is_lead_byte(b)) start_char(b);
                end
            end
            default: begin
                close_pred_seq();
                start_char(b);
            end
        endcase
        for (int i = 0; i < step_cnt; i++) begin
            r = step_out[i];
            r.last_of_run = (i == step_cnt - 1);
            pending_chars.push_back(r);
        end
    endtask

    // ---------------------------------------------------------------
    // monitor: sampled at the rising edge, before the block updates
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        utf8sc_pkg::t_result got;
        utf8sc_pkg::t_result want;
        if (i_rst_n) begin
            if (char_ch.valid && char_ch.ready) begin
                got.char_bytes  = char_ch.char_bytes;
                got.char_len    = char_ch.char_len;
                got.error_kind  = char_ch.error_kind;
                got.bom_kind    = char_ch.bom_kind;
                got.last_of_run = char_ch.last_of_run;
                if (pending_chars.size() == 0) begin
                    report_mismatch($sformatf("character %h with nothing pending",
                                              got.char_bytes));
                end else begin
                    want = pending_chars.pop_front();
                    if (got.char_bytes !== want.char_bytes)
                        report_mismatch($sformatf("char_bytes %h, want %h",
                                                  got.char_bytes, want.char_bytes));
                    if (got.char_len !== want.char_len)
                        report_mismatch($sformatf("char_len %0d, want %0d",
                                                  got.char_len, want.char_len));
                    if (got.error_kind !== want.error_kind)
                        report_mismatch($sformatf("error_kind %0d, want %0d",
                                                  got.error_kind, want.error_kind));
                    if (got.bom_kind !== want.bom_kind)
                        report_mismatch($sformatf("bom_kind %0d, want %0d",
                                                  got.bom_kind, want.bom_kind));
                    if (got.last_of_run !== want.last_of_run)
                        report_mismatch($sformatf("last_of_run %0d, want %0d",
                                                  got.last_of_run, want.last_of_run));
                end
                chars_checked++;
            end
            // a byte transaction feeds the predictor; its results reach the output through the registered result queue
            if (byte_ch.valid && byte_ch.ready)
                predict_byte(byte_ch.in_byte);
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    // one byte transaction; valid stays high into the next call unless it idles
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= b;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    function automatic logic [7:0] rand_trail();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    task automatic test_single_bytes();
        // ascii extremes, a stray trailing byte and both illegal leads
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(utf8sc_pkg::BYTE_C0);
        send_byte(utf8sc_pkg::BYTE_C1);
    endtask

    task automatic test_complete_sequences();
        send_byte(8'hC2); send_byte(8'h80);
        send_byte(8'hEF); send_byte(8'hBF); send_byte(8'hBF);
    endtask

    task automatic test_malformed_sequences();
        // broken by ascii: replacement then the ascii byte in the same step
        send_byte(8'hC2); send_byte(8'h41);
        // broken by C1: the illegal byte is dropped
        send_byte(8'hDF); send_byte(utf8sc_pkg::BYTE_C1);
        // broken by a four byte lead that then completes at the top of the range
        send_byte(8'hE0); send_byte(8'hF4);
        send_byte(8'hBF); send_byte(8'hBF); send_byte(8'hBF);
        // F5 with a partner that is not a byte order mark, partner reprocessed
        send_byte(utf8sc_pkg::BYTE_F5); send_byte(8'h41);
    endtask

    task automatic test_byte_order_marks();
        send_byte(8'hEF); send_byte(8'hBB); send_byte(8'hBF);
        send_byte(8'hFE); send_byte(8'hFF);
        send_byte(8'hFF); send_byte(8'hFE);
    endtask

    // mostly well-formed characters with random content, plus broken ones and noise
    task automatic test_random_stream(input int idle_pct, input int stall_pct,
                                      input int n_bytes);
        int stop_at;
        int pick;
        int len;
        int keep;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                case ($urandom_range(0, 9)) inside
                    0, 1, 2: send_byte(8'($urandom_range(0, 127)));
                    3, 4: begin
                        send_byte(8'($urandom_range(8'hC2, 8'hDF)));
                        send_byte(rand_trail());
                    end
                    5, 6: begin
                        send_byte(8'($urandom_range(8'hE0, 8'hEF)));
                        send_byte(rand_trail());
                        send_byte(rand_trail());
                    end
                    7, 8: begin
                        send_byte(8'($urandom_range(8'hF0, 8'hF4)));
                        send_byte(rand_trail());
                        send_byte(rand_trail());
                        send_byte(rand_trail());
                    end
                    default: begin
                        case ($urandom_range(0, 2))
                            0: begin
                                send_byte(8'hEF); send_byte(8'hBB); send_byte(8'hBF);
                            end
                            1: begin
                                send_byte(8'hFE); send_byte(8'hFF);
                            end
                            default: begin
                                send_byte(8'hFF); send_byte(8'hFE);
                            end
                        endcase
                    end
                endcase
            end else if (pick < 88) begin
                // truncated sequence, ended by ascii or any lead-class byte
                len = $urandom_range(2, 4);
                send_byte(len == 2 ? 8'($urandom_range(8'hC2, 8'hDF)) :
                          len == 3 ? 8'($urandom_range(8'hE0, 8'hEF)) :
                                     8'($urandom_range(8'hF0, 8'hF4)));
                keep = $urandom_range(0, len - 2);
                for (int i = 0; i < keep; i++) send_byte(rand_trail());
                if ($urandom_range(0, 1))
                    send_byte(8'($urandom_range(0, 127)));
                else
                    send_byte(8'($urandom_range(8'hC0, 8'hFF)));
            end else if (pick < 94) begin
                // F5-FF lead with an arbitrary partner
                send_byte(8'($urandom_range(8'hF5, 8'hFF)));
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        int guard;
        byte_ch.valid   = 1'b0;
        byte_ch.in_byte = 8'h00;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        bytes_sent      = 0;
        chars_checked   = 0;
        mismatches      = 0;
        close_pred_seq();

        // synchronous reset, released at a falling edge
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part runs with light pressure on both sides
        sender_idle_pct = 22;
        recv_stall_pct  = 22;
        test_single_bytes();
        test_complete_sequences();
        test_malformed_sequences();
        test_byte_order_marks();

        // random stream through every pressure phase, first one without idling
        test_random_stream(0, 0, 325);
        test_random_stream(66, 0, 325);
        test_random_stream(0, 66, 325);
        test_random_stream(22, 22, 325);

        @(negedge i_clk);
        byte_ch.valid <= 1'b0;

        // drain: every predicted character has to show up
        guard = 0;
        while (pending_chars.size() > 0 && guard < 10000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_chars.size() > 0)
            report_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));

        $display("sent %0d bytes and checked %0d characters", bytes_sent, chars_checked);
        $display("covered ascii, 2-4 byte sequences, broken and stray bytes, byte order marks");
        if (mismatches == 0) begin
            $display("[utf8_sequence_collector] OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("[utf8_sequence_collector] ERROR");
        end
        $finish;
    end

endmodule
